// ===== design/metronome_click_scheduler_defines.svh =====
// Assertion macros for the checker of the click scheduler.
// Each macro samples on the rising edge of i_clk and is disabled while i_rst_n is low.
`ifndef METRONOME_CLICK_SCHEDULER_DEFINES_SVH
`define METRONOME_CLICK_SCHEDULER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mcs_pkg.sv =====
`timescale 1ns / 1ps

package mcs_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int MAX_CLICKS  = 8;
    localparam int WAVE_DEPTH  = 4096;
    localparam int SAMPLE_BITS = 16;

    localparam int CLICK_W     = (MAX_CLICKS > 1) ? $clog2(MAX_CLICKS) : 1;
    localparam int WADDR_W     = $clog2(WAVE_DEPTH);
    localparam int LEN_W       = $clog2(WAVE_DEPTH + 1);
    localparam int STORE_AW    = WADDR_W + 2;
    localparam int STORE_DEPTH = 4 << WADDR_W;
    localparam int SUM_W       = SAMPLE_BITS + CLICK_W + 1;
    localparam int VOL_W       = 16;
    localparam int PROD_W      = SUM_W + VOL_W + 1;
    localparam int Q_FRAC      = 15;
    localparam int VOL_UNITY   = 32768;

    localparam int PADDR_W     = 5;

    localparam int MOD_W       = 7;
    localparam int MOD_CAND_W  = 13;
    localparam logic [2:0] MOD_TOP = 3'd6;

    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_START = 3'd1;
    localparam logic [2:0] REQ_STOP  = 3'd2;
    localparam logic [2:0] REQ_WSAMP = 3'd3;
    localparam logic [2:0] REQ_WLEN  = 3'd4;

    localparam logic [2:0] REG_FPB    = 3'd0;
    localparam logic [2:0] REG_ANCHOR = 3'd1;
    localparam logic [2:0] REG_BPB    = 3'd2;
    localparam logic [2:0] REG_PLEN   = 3'd3;
    localparam logic [2:0] REG_MASK   = 3'd4;
    localparam logic [2:0] REG_VOICE  = 3'd5;
    localparam logic [2:0] REG_VOL    = 3'd6;

    localparam logic [23:0] FPB_RST    = 24'd24000;
    localparam logic [15:0] ANCHOR_RST = 16'd480;
    localparam logic [6:0]  BPB_RST    = 7'd4;
    localparam logic [4:0]  PLEN_RST   = 5'd4;
    localparam logic [15:0] MASK_RST   = 16'd1;
    localparam logic        VOICE_RST  = 1'b0;
    localparam logic [15:0] VOL_RST    = 16'd32768;

endpackage

// ===== design/mcs_ram.sv =====
`timescale 1ns / 1ps

module mcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/metronome_click_scheduler.sv =====
`timescale 1ns / 1ps

// Metronome click scheduler. Each tick word is one audio frame and returns exactly one
// output word; start, stop and waveform write words are taken without a stall and return
// nothing. A tick keeps the input stalled through the beat, mix, drain, multiply and output
// states, and on a beat through both remainder passes. The click slots are mixed one per
// cycle through the single read port of the waveform RAM, and the beat bookkeeping (accent
// pattern position and bar wrap) runs through one shared restoring remainder unit, seven
// steps for each remainder. A finished output word waits in the output register; the next
// tick can complete only once that word has been taken. The waveform RAM is not cleared
// after reset, so every sample that a click will play must be written before it is used.
// Configuration registers sit at byte address 4 times their index on the APB port.
module metronome_click_scheduler (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [mcs_pkg::PADDR_W-1:0]            paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [2:0]                             i_in_req_type,
    input  logic [1:0]                             i_in_wave_sel,
    input  logic [11:0]                            i_in_wave_addr,
    input  logic signed [mcs_pkg::SAMPLE_BITS-1:0] i_in_wave_value,
    input  logic [12:0]                            i_in_wave_length,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [mcs_pkg::SAMPLE_BITS-1:0] o_out_sample,
    output logic                                   o_out_beat_started,
    output logic                                   o_out_accented,
    output logic [5:0]                             o_out_beat_number,
    output logic                                   o_out_click_dropped
);

    import mcs_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BEAT  = 4'd1;
    localparam logic [3:0] S_MODA  = 4'd2;
    localparam logic [3:0] S_ALLOC = 4'd3;
    localparam logic [3:0] S_MODB  = 4'd4;
    localparam logic [3:0] S_MIX   = 4'd5;
    localparam logic [3:0] S_DRAIN = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    localparam int Q_W = PROD_W + 1 - Q_FRAC;

    logic [23:0]              r_fpb;
    logic [15:0]              r_anchor;
    logic [6:0]               r_bpb;
    logic [4:0]               r_plen;
    logic [15:0]              r_mask;
    logic                     r_voice;
    logic [15:0]              r_vol;

    logic [3:0]               r_state;
    logic                     r_playing;
    logic                     r_anchored;
    logic [23:0]              r_ftb;
    logic [5:0]               r_bib;
    logic [MAX_CLICKS-1:0]    r_slot_valid;
    logic [1:0]               r_slot_wave [MAX_CLICKS];
    logic [LEN_W-1:0]         r_slot_cur  [MAX_CLICKS];
    logic [LEN_W-1:0]         r_wave_len  [4];

    logic [MOD_W-1:0]         r_rem;
    logic [MOD_W-1:0]         r_div;
    logic [2:0]               r_k;

    logic                     r_beat;
    logic                     r_acc;
    logic [5:0]               r_num;
    logic                     r_drop;

    logic [CLICK_W-1:0]       r_idx;
    logic                     r_pend;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [PROD_W-1:0] r_prod;

    logic                         r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                         r_out_beat;
    logic                         r_out_acc;
    logic [5:0]                   r_out_num;
    logic                         r_out_drop;

    logic                     cfg_wr;
    logic [2:0]               cfg_reg;
    logic                     accept;
    logic [23:0]              ftb_eff;
    logic [MOD_W-1:0]         plen_eff;
    logic [MOD_W-1:0]         bpb_eff;
    logic [15:0]              vol_eff;
    logic [MOD_CAND_W-1:0]    mod_cand;
    logic [MOD_W-1:0]         rem_next;
    logic                     acc_bit;
    logic [1:0]               w_sel;
    logic                     free_found;
    logic [CLICK_W-1:0]       free_idx;
    logic                     cur_valid;
    logic [1:0]               cur_w;
    logic [LEN_W-1:0]         cur_len;
    logic [LEN_W-1:0]         cur_c;
    logic [LEN_W-1:0]         cur_inc;
    logic                     cur_live;
    logic [31:0]              addr_ext;
    logic [31:0]              len_ext;
    logic                     ram_we;
    logic [STORE_AW-1:0]      ram_waddr;
    logic [STORE_AW-1:0]      ram_raddr;
    logic [SAMPLE_BITS-1:0]   ram_rdata;
    logic signed [PROD_W:0]   rnd;
    logic [Q_W-1:0]           q;
    logic                     q_fits;
    logic signed [SAMPLE_BITS-1:0] q_sat;
    logic                     out_load;

    // Configuration registers.
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_reg = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fpb    <= FPB_RST;
            r_anchor <= ANCHOR_RST;
            r_bpb    <= BPB_RST;
            r_plen   <= PLEN_RST;
            r_mask   <= MASK_RST;
            r_voice  <= VOICE_RST;
            r_vol    <= VOL_RST;
        end else if (cfg_wr) begin
            case (cfg_reg)
                REG_FPB:    r_fpb    <= pwdata[23:0];
                REG_ANCHOR: r_anchor <= pwdata[15:0];
                REG_BPB:    r_bpb    <= pwdata[6:0];
                REG_PLEN:   r_plen   <= pwdata[4:0];
                REG_MASK:   r_mask   <= pwdata[15:0];
                REG_VOICE:  r_voice  <= pwdata[0];
                REG_VOL:    r_vol    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_reg)
            REG_FPB:    prdata = 32'(r_fpb);
            REG_ANCHOR: prdata = 32'(r_anchor);
            REG_BPB:    prdata = 32'(r_bpb);
            REG_PLEN:   prdata = 32'(r_plen);
            REG_MASK:   prdata = 32'(r_mask);
            REG_VOICE:  prdata = 32'(r_voice);
            REG_VOL:    prdata = 32'(r_vol);
            default:    prdata = 32'd0;
        endcase
    end

    // Effective settings.
    assign ftb_eff  = r_anchored ? r_ftb : 24'(r_anchor);
    assign plen_eff = (32'(r_plen) > MAX_PATTERN) ? MOD_W'(MAX_PATTERN) : MOD_W'(r_plen);
    assign bpb_eff  = (r_bpb == 7'd0) ? 7'd1 : ((r_bpb > 7'd64) ? 7'd64 : r_bpb);
    assign vol_eff  = (32'(r_vol) > VOL_UNITY) ? VOL_W'(VOL_UNITY) : r_vol;

    // Shared remainder unit: one restoring step per cycle.
    assign mod_cand = MOD_CAND_W'(r_div) << r_k;
    assign rem_next = (MOD_CAND_W'(r_rem) >= mod_cand) ? (r_rem - mod_cand[MOD_W-1:0]) : r_rem;

    assign acc_bit = (r_rem < MOD_W'(16)) && r_mask[r_rem[3:0]];
    assign w_sel   = {r_voice, acc_bit};

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = MAX_CLICKS - 1; k >= 0; k--) begin
            if (!r_slot_valid[k]) begin
                free_found = 1'b1;
                free_idx   = CLICK_W'(k);
            end
        end
    end

    // Slot under the mixer this cycle.
    assign cur_valid = r_slot_valid[r_idx];
    assign cur_w     = r_slot_wave[r_idx];
    assign cur_len   = r_wave_len[cur_w];
    assign cur_c     = r_slot_cur[r_idx];
    assign cur_inc   = cur_c + LEN_W'(1);
    assign cur_live  = (r_state == S_MIX) && cur_valid && (cur_c < cur_len);

    // Waveform store.
    assign accept    = i_in_valid & ~o_in_stall;
    assign addr_ext  = 32'(i_in_wave_addr);
    assign len_ext   = 32'(i_in_wave_length);
    assign ram_we    = accept && (i_in_req_type == REQ_WSAMP) && (addr_ext < WAVE_DEPTH);
    assign ram_waddr = {i_in_wave_sel, addr_ext[WADDR_W-1:0]};
    assign ram_raddr = {cur_w, cur_c[WADDR_W-1:0]};

    mcs_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(STORE_DEPTH)
    ) u_wave_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_in_wave_value),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Rounding half up and saturation.
    assign rnd    = (PROD_W + 1)'(r_prod) + (PROD_W + 1)'(1 << (Q_FRAC - 1));
    assign q      = rnd[PROD_W:Q_FRAC];
    assign q_fits = (q[Q_W-1:SAMPLE_BITS-1] == '0) || (q[Q_W-1:SAMPLE_BITS-1] == '1);
    assign q_sat  = q_fits ? q[SAMPLE_BITS-1:0] :
                    (q[Q_W-1] ? {1'b1, {(SAMPLE_BITS - 1){1'b0}}}
                              : {1'b0, {(SAMPLE_BITS - 1){1'b1}}});

    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_playing    <= 1'b0;
            r_anchored   <= 1'b0;
            r_ftb        <= '0;
            r_bib        <= '0;
            r_slot_valid <= '0;
            r_pend       <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_wave_len[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_in_req_type)
                            REQ_TICK: begin
                                r_beat  <= 1'b0;
                                r_acc   <= 1'b0;
                                r_num   <= '0;
                                r_drop  <= 1'b0;
                                r_state <= S_BEAT;
                            end
                            REQ_START: begin
                                r_playing    <= 1'b1;
                                r_anchored   <= 1'b0;
                                r_bib        <= '0;
                                r_ftb        <= '0;
                                r_slot_valid <= '0;
                            end
                            REQ_STOP: begin
                                r_playing  <= 1'b0;
                                r_anchored <= 1'b0;
                            end
                            REQ_WLEN: begin
                                r_wave_len[i_in_wave_sel] <= (len_ext > WAVE_DEPTH) ?
                                    LEN_W'(WAVE_DEPTH) : LEN_W'(len_ext);
                            end
                            default: ;
                        endcase
                    end
                end
                S_BEAT: begin
                    r_idx  <= '0;
                    r_pend <= 1'b0;
                    r_sum  <= '0;
                    if (r_playing) begin
                        r_anchored <= 1'b1;
                        if (ftb_eff == 24'd0) begin
                            r_beat  <= 1'b1;
                            r_num   <= r_bib;
                            r_ftb   <= (r_fpb == 24'd0) ? 24'd0 : r_fpb - 24'd1;
                            r_rem   <= (plen_eff == '0) ? '0 : MOD_W'(r_bib);
                            r_div   <= (plen_eff == '0) ? MOD_W'(1) : plen_eff;
                            r_k     <= MOD_TOP;
                            r_state <= S_MODA;
                        end else begin
                            r_ftb   <= ftb_eff - 24'd1;
                            r_state <= S_MIX;
                        end
                    end else begin
                        r_anchored <= 1'b0;
                        r_state    <= S_MIX;
                    end
                end
                S_MODA: begin
                    r_rem <= rem_next;
                    r_k   <= r_k - 3'd1;
                    if (r_k == 3'd0) begin
                        r_state <= S_ALLOC;
                    end
                end
                S_ALLOC: begin
                    r_acc <= acc_bit;
                    if (r_wave_len[w_sel] != '0) begin
                        if (free_found) begin
                            r_slot_valid[free_idx] <= 1'b1;
                            r_slot_wave[free_idx]  <= w_sel;
                            r_slot_cur[free_idx]   <= '0;
                        end else begin
                            r_drop <= 1'b1;
                        end
                    end
                    r_rem   <= MOD_W'(r_bib) + MOD_W'(1);
                    r_div   <= bpb_eff;
                    r_k     <= MOD_TOP;
                    r_state <= S_MODB;
                end
                S_MODB: begin
                    r_rem <= rem_next;
                    r_k   <= r_k - 3'd1;
                    if (r_k == 3'd0) begin
                        r_bib   <= rem_next[5:0];
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    if (r_pend) begin
                        r_sum <= r_sum + SUM_W'($signed(ram_rdata));
                    end
                    r_pend <= cur_live;
                    if (cur_valid) begin
                        if (!cur_live) begin
                            r_slot_valid[r_idx] <= 1'b0;
                        end else begin
                            r_slot_cur[r_idx] <= cur_inc;
                            if (cur_inc >= cur_len) begin
                                r_slot_valid[r_idx] <= 1'b0;
                            end
                        end
                    end
                    if (r_idx == CLICK_W'(MAX_CLICKS - 1)) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + CLICK_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (r_pend) begin
                        r_sum <= r_sum + SUM_W'($signed(ram_rdata));
                    end
                    r_pend  <= 1'b0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= r_sum * $signed({1'b0, vol_eff});
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_sample <= q_sat;
            r_out_beat   <= r_beat;
            r_out_acc    <= r_acc;
            r_out_num    <= r_num;
            r_out_drop   <= r_drop;
        end
    end

    assign o_in_stall          = (r_state != S_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_out_sample        = r_out_sample;
    assign o_out_beat_started  = r_out_beat;
    assign o_out_accented      = r_out_acc;
    assign o_out_beat_number   = r_out_num;
    assign o_out_click_dropped = r_out_drop;

endmodule

// ===== design/mcs_checker.sv =====
`timescale 1ns / 1ps
`include "metronome_click_scheduler_defines.svh"

module mcs_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_stall,
    input logic [2:0]                             i_in_req_type,
    input logic                                   o_out_valid,
    input logic                                   i_out_stall,
    input logic signed [mcs_pkg::SAMPLE_BITS-1:0] o_out_sample,
    input logic                                   o_out_beat_started,
    input logic                                   o_out_accented,
    input logic [5:0]                             o_out_beat_number,
    input logic                                   o_out_click_dropped
);

    import mcs_pkg::*;

    // A tick word starts work that stalls the input.
    `MCS_ASSERT_NEXT(a_tick_busy,
        i_in_valid && !o_in_stall && i_in_req_type == REQ_TICK,
        o_in_stall, "tick word did not start work")

    // Any other word completes in the cycle it is taken.
    `MCS_ASSERT_NEXT(a_other_quick,
        i_in_valid && !o_in_stall && i_in_req_type != REQ_TICK,
        !o_in_stall, "non-tick word kept the input stalled")

    // Beat details are reported only on a beat.
    `MCS_ASSERT_IMPL(a_beat_fields,
        o_out_valid && !o_out_beat_started,
        !o_out_accented && o_out_beat_number == 6'd0 && !o_out_click_dropped,
        "beat fields set without a beat")

    // A stalled output word holds.
    `MCS_ASSERT_NEXT(a_out_hold,
        o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_sample) && $stable(o_out_beat_started),
        "stalled output word changed")

endmodule

bind metronome_click_scheduler mcs_checker u_mcs_checker (.*);

// ===== sim/tb_metronome_click_scheduler.sv =====
`timescale 1ns / 1ps

module tb_metronome_click_scheduler;
    import mcs_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LEN_FIELD_MAX = (1 << 13) - 1;
    localparam int REQ_CODES     = 8;
    localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [2:0]                    req;
        logic [1:0]                    sel;
        logic [11:0]                   addr;
        logic signed [SAMPLE_BITS-1:0] value;
        logic [12:0]                   wlen;
    } word_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          beat;
        logic                          accented;
        logic [5:0]                    number;
        logic                          dropped;
    } frame_t;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [PADDR_W-1:0]            paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [2:0]                    i_in_req_type = '0;
    logic [1:0]                    i_in_wave_sel = '0;
    logic [11:0]                   i_in_wave_addr = '0;
    logic signed [SAMPLE_BITS-1:0] i_in_wave_value = '0;
    logic [12:0]                   i_in_wave_length = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_out_sample;
    logic                          o_out_beat_started;
    logic                          o_out_accented;
    logic [5:0]                    o_out_beat_number;
    logic                          o_out_click_dropped;

    metronome_click_scheduler u_top (.*);

    always #5 i_clk = ~i_clk;

    word_t      pending_words[$];
    frame_t     expected_frames[$];
    idle_mode_t idle_mode = IDLE_NONE;
    int         mismatches = 0;
    int         quiet_cycles = 0;
    bit         sample_written [4][WAVE_DEPTH];

    logic [23:0] cfg_fpb    = FPB_RST;
    logic [15:0] cfg_anchor = ANCHOR_RST;
    logic [6:0]  cfg_bpb    = BPB_RST;
    logic [4:0]  cfg_plen   = PLEN_RST;
    logic [15:0] cfg_mask   = MASK_RST;
    logic        cfg_voice  = VOICE_RST;
    logic [15:0] cfg_vol    = VOL_RST;

    bit                            running;
    bit                            anchor_done;
    int                            beat_countdown;
    int                            bar_position;
    bit                            click_on [MAX_CLICKS];
    int                            click_wave [MAX_CLICKS];
    int                            click_pos [MAX_CLICKS];
    int                            wave_size [4];
    logic signed [SAMPLE_BITS-1:0] wave_mem [STORE_DEPTH];

    task automatic take_word(input word_t w);
        frame_t f;
        longint mix_sum;
        longint scaled;
        int plen;
        int bpb;
        int idx;
        int wv;
        int slot;
        int len;
        int vol;
        f = '0;
        case (w.req)
            REQ_START: begin
                running = 1'b1;
                anchor_done = 1'b0;
                bar_position = 0;
                beat_countdown = 0;
                for (int k = 0; k < MAX_CLICKS; k++) click_on[k] = 1'b0;
            end
            REQ_STOP: begin
                running = 1'b0;
                anchor_done = 1'b0;
            end
            REQ_WSAMP: begin
                wave_mem[{w.sel, w.addr}] = w.value;
            end
            REQ_WLEN: begin
                wave_size[w.sel] = (int'(w.wlen) > WAVE_DEPTH) ? WAVE_DEPTH : int'(w.wlen);
            end
            REQ_TICK: begin
                if (running) begin
                    if (!anchor_done) begin
                        beat_countdown = int'(cfg_anchor);
                        anchor_done = 1'b1;
                    end
                    if (beat_countdown == 0) begin
                        plen = (int'(cfg_plen) > MAX_PATTERN) ? MAX_PATTERN : int'(cfg_plen);
                        bpb = (cfg_bpb == 0) ? 1 : ((int'(cfg_bpb) > 64) ? 64 : int'(cfg_bpb));
                        idx = (plen > 0) ? bar_position % plen : 0;
                        f.beat = 1'b1;
                        f.number = 6'(bar_position);
                        f.accented = (idx < 16) && cfg_mask[idx];
                        wv = 2 * int'(cfg_voice) + int'(f.accented);
                        if (wave_size[wv] > 0) begin
                            slot = -1;
                            for (int k = MAX_CLICKS - 1; k >= 0; k--)
                                if (!click_on[k]) slot = k;
                            if (slot < 0) begin
                                f.dropped = 1'b1;
                            end else begin
                                click_on[slot] = 1'b1;
                                click_wave[slot] = wv;
                                click_pos[slot] = 0;
                            end
                        end
                        bar_position = (bar_position + 1) % bpb;
                        beat_countdown = ((cfg_fpb == 0) ? 1 : int'(cfg_fpb)) - 1;
                    end else begin
                        beat_countdown--;
                    end
                end else begin
                    anchor_done = 1'b0;
                end
                mix_sum = 0;
                for (int k = 0; k < MAX_CLICKS; k++) begin
                    if (click_on[k]) begin
                        len = wave_size[click_wave[k]];
                        if (click_pos[k] >= len) begin
                            click_on[k] = 1'b0;
                        end else begin
                            mix_sum += wave_mem[click_wave[k] * WAVE_DEPTH + click_pos[k]];
                            click_pos[k]++;
                            if (click_pos[k] >= len) click_on[k] = 1'b0;
                        end
                    end
                end
                vol = (int'(cfg_vol) > VOL_UNITY) ? VOL_UNITY : int'(cfg_vol);
                scaled = (mix_sum * vol + (longint'(1) << (Q_FRAC - 1))) >>> Q_FRAC;
                if (scaled > SAMPLE_MAX) scaled = SAMPLE_MAX;
                if (scaled < SAMPLE_MIN) scaled = SAMPLE_MIN;
                f.sample = SAMPLE_BITS'(scaled);
                expected_frames.insert(expected_frames.size(), f);
            end
            default: begin
            end
        endcase
    endtask

    function automatic bit sender_idle();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 48;
            IDLE_BOTH:   return $urandom_range(0, 99) < 12;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 48;
            IDLE_BOTH:     return $urandom_range(0, 99) < 12;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic int written_prefix(input int sel);
        int n = 0;
        while (n < WAVE_DEPTH && sample_written[sel][n]) n++;
        return n;
    endfunction

    always @(posedge i_clk) begin : drive_words
        word_t nxt;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                take_word({i_in_req_type, i_in_wave_sel, i_in_wave_addr, i_in_wave_value,
                           i_in_wave_length});
            if (!i_in_valid || !o_in_stall) begin
                if (pending_words.size() != 0 && !sender_idle()) begin
                    nxt = pending_words.pop_front();
                    i_in_valid <= 1'b1;
                    {i_in_req_type, i_in_wave_sel, i_in_wave_addr, i_in_wave_value,
                     i_in_wave_length} <= nxt;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_frames
        frame_t want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_frames.size() == 0) begin
                    $error("output word with no tick waiting for it");
                    mismatches++;
                end else begin
                    want = expected_frames.pop_front();
                    if (o_out_sample !== want.sample) begin
                        $error("sample: expected %0d, got %0d", want.sample, o_out_sample);
                        mismatches++;
                    end
                    if (o_out_beat_started !== want.beat) begin
                        $error("beat_started: expected %0d, got %0d", want.beat,
                               o_out_beat_started);
                        mismatches++;
                    end
                    if (o_out_accented !== want.accented) begin
                        $error("accented: expected %0d, got %0d", want.accented, o_out_accented);
                        mismatches++;
                    end
                    if (o_out_beat_number !== want.number) begin
                        $error("beat_number: expected %0d, got %0d", want.number,
                               o_out_beat_number);
                        mismatches++;
                    end
                    if (o_out_click_dropped !== want.dropped) begin
                        $error("click_dropped: expected %0d, got %0d", want.dropped,
                               o_out_click_dropped);
                        mismatches++;
                    end
                end
            end
            i_out_stall <= receiver_stall();
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input int val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FPB:    cfg_fpb = 24'(val);
            REG_ANCHOR: cfg_anchor = 16'(val);
            REG_BPB:    cfg_bpb = 7'(val);
            REG_PLEN:   cfg_plen = 5'(val);
            REG_MASK:   cfg_mask = 16'(val);
            REG_VOICE:  cfg_voice = 1'(val);
            REG_VOL:    cfg_vol = 16'(val);
            default: begin
            end
        endcase
    endtask

    task automatic set_config(input int fpb, input int anchor, input int bpb, input int plen,
                              input int mask, input int voice, input int vol);
        write_reg(REG_FPB, fpb);
        write_reg(REG_ANCHOR, anchor);
        write_reg(REG_BPB, bpb);
        write_reg(REG_PLEN, plen);
        write_reg(REG_MASK, mask);
        write_reg(REG_VOICE, voice);
        write_reg(REG_VOL, vol);
    endtask

    task automatic push_word(input logic [2:0] req, input int sel, input int addr,
                             input int value, input int wlen);
        word_t w;
        w.req = req;
        w.sel = 2'(sel);
        w.addr = 12'(addr);
        w.value = SAMPLE_BITS'(value);
        w.wlen = 13'(wlen);
        if (req == REQ_WSAMP) sample_written[w.sel][w.addr] = 1'b1;
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic settle();
        while (pending_words.size() != 0 || i_in_valid || expected_frames.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_random_words(input int count);
        int pick;
        int sel;
        int addr;
        int top;
        int value;
        int wlen;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            sel = $urandom_range(0, 3);
            addr = $urandom_range(0, WAVE_DEPTH - 1);
            value = $urandom_range(0, 65535);
            wlen = $urandom_range(0, LEN_FIELD_MAX);
            top = written_prefix(sel);
            if (pick < 68) begin
                push_word(REQ_TICK, sel, addr, value, wlen);
            end else if (pick < 72) begin
                push_word(REQ_START, sel, addr, value, wlen);
            end else if (pick < 75) begin
                push_word(REQ_STOP, sel, addr, value, wlen);
            end else if (pick < 87) begin
                if (pick < 83 && top < WAVE_DEPTH) addr = top;
                push_word(REQ_WSAMP, sel, addr, value, wlen);
            end else if (pick < 95) begin
                wlen = (pick < 92) ? $urandom_range(top / 2, top) : $urandom_range(0, top);
                push_word(REQ_WLEN, sel, addr, value, wlen);
            end else if (pick < 97) begin
                // An oversized length is taken back before any tick can play past the
                // samples that have been written.
                push_word(REQ_WLEN, sel, addr, value, $urandom_range(WAVE_DEPTH, LEN_FIELD_MAX));
                push_word(REQ_WLEN, sel, addr, value, top);
            end else begin
                push_word(3'($urandom_range(int'(REQ_WLEN) + 1, REQ_CODES - 1)), sel, addr,
                          value, wlen);
            end
        end
    endtask

    task automatic run_phase(input idle_mode_t mode, input int count, input int fpb,
                             input int anchor, input int bpb, input int plen, input int mask,
                             input int voice, input int vol);
        int top;
        int wlen;
        settle();
        set_config(fpb, anchor, bpb, plen, mask, voice, vol);
        idle_mode = mode;
        for (int s = 0; s < 4; s++) begin
            top = written_prefix(s);
            if (top < 40) begin
                repeat ($urandom_range(3, 8)) begin
                    push_word(REQ_WSAMP, s, top, $urandom_range(0, 65535),
                              $urandom_range(0, LEN_FIELD_MAX));
                    top++;
                end
            end
            wlen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(top / 2, top);
            push_word(REQ_WLEN, s, $urandom_range(0, WAVE_DEPTH - 1), $urandom_range(0, 65535),
                      wlen);
        end
        push_word(REQ_START, 0, 0, 0, 0);
        add_random_words(count);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_config(2, 1, 3, 2, 1, 0, VOL_UNITY);
        push_word(REQ_WSAMP, 0, 0, 32767, 0);
        push_word(REQ_WSAMP, 0, 1, -32768, 0);
        push_word(REQ_WSAMP, 1, 0, -32768, 0);
        push_word(REQ_WSAMP, 1, 1, 32767, 0);
        push_word(REQ_WSAMP, 2, 0, 1, 0);
        push_word(REQ_WSAMP, 3, WAVE_DEPTH - 1, 16'h5555, 0);
        push_word(REQ_WLEN, 0, 0, 0, 2);
        push_word(REQ_WLEN, 1, 0, 0, 2);
        push_word(REQ_WLEN, 2, 0, 0, LEN_FIELD_MAX);
        push_word(REQ_WLEN, 2, 0, 0, WAVE_DEPTH);
        push_word(REQ_WLEN, 2, 0, 0, 1);
        push_word(REQ_WLEN, 3, 0, 0, 0);
        push_word(REQ_TICK, 3, WAVE_DEPTH - 1, -1, LEN_FIELD_MAX);
        for (int r = int'(REQ_WLEN) + 1; r < REQ_CODES; r++)
            push_word(3'(r), 3, WAVE_DEPTH - 1, -1, LEN_FIELD_MAX);
        push_word(REQ_START, 0, 0, 0, 0);
        repeat (6) push_word(REQ_TICK, 0, 0, 0, 0);
        push_word(REQ_STOP, 0, 0, 0, 0);
        repeat (2) push_word(REQ_TICK, 0, 0, 0, 0);

        run_phase(IDLE_NONE, 100, 1, 0, 4, 4, $urandom_range(0, 65535), 0, VOL_UNITY);
        run_phase(IDLE_SENDER, 100, 3, 5, 3, 5, $urandom_range(0, 65535), 1,
                  $urandom_range(0, VOL_UNITY));
        run_phase(IDLE_RECEIVER, 100, 0, 0, 0, 0, 16'hFFFF, 0, 16'hFFFF);
        run_phase(IDLE_BOTH, 60, 24'hFFFFFF, 16'hFFFF, 64, MAX_PATTERN, 0, 1, 0);
        run_phase(IDLE_NONE, 100, 2, 1, 127, 31, $urandom_range(0, 65535),
                  $urandom_range(0, 1), VOL_UNITY - 1);
        for (int p = 5; p < 13; p++)
            run_phase(idle_mode_t'(p % 4), 110, $urandom_range(1, 6), $urandom_range(0, 8),
                      $urandom_range(0, 70), $urandom_range(0, 20), $urandom_range(0, 65535),
                      $urandom_range(0, 1),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, VOL_UNITY));

        settle();
        if (mismatches == 0 && expected_frames.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
